// File: sv/lcf_pkg.sv
// Package: lattice tags, operation codes and the queue entry type.
`default_nettype none
package lcf_pkg;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned VW     = 64;
    localparam int unsigned HW     = VW / 2;

    localparam logic [1:0] TAG_BOTTOM = 2'd0;
    localparam logic [1:0] TAG_CONST  = 2'd1;
    localparam logic [1:0] TAG_TOP    = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_SDIV  = 3'd3,
        OP_UDIV  = 3'd4,
        OP_SREM  = 3'd5,
        OP_UREM  = 3'd6,
        OP_OTHER = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        K_DONE = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind          kind;
        t_op            op;
        logic [1:0]     tag;
        logic [VW-1:0]  value;
        logic [VW-1:0]  a;
        logic [VW-1:0]  b;
    } t_item;
endpackage
`default_nettype wire

// File: sv/lcf_front.sv
// Front end: classifies a transaction and folds the cases that need no multiplier or divider.
`default_nettype none
module lcf_front (
    input  wire logic [2:0]           i_operation,
    input  wire logic [1:0]           i_lhs_tag,
    input  wire logic [63:0]          i_lhs_value,
    input  wire logic [1:0]           i_rhs_tag,
    input  wire logic [63:0]          i_rhs_value,
    output lcf_pkg::t_item            o_item
);
    import lcf_pkg::*;

    always_comb begin
        o_item       = '0;
        o_item.op    = t_op'(i_operation);
        o_item.a     = i_lhs_value;
        o_item.b     = i_rhs_value;
        o_item.kind  = K_DONE;
        o_item.tag   = TAG_TOP;
        o_item.value = '0;
        if (i_lhs_tag == TAG_BOTTOM || i_rhs_tag == TAG_BOTTOM) begin
            o_item.tag = TAG_BOTTOM;
        end else if (i_lhs_tag == TAG_CONST && i_rhs_tag == TAG_CONST) begin
            case (t_op'(i_operation))
                OP_ADD: begin
                    o_item.tag   = TAG_CONST;
                    o_item.value = i_lhs_value + i_rhs_value;
                end
                OP_SUB: begin
                    o_item.tag   = TAG_CONST;
                    o_item.value = i_lhs_value - i_rhs_value;
                end
                OP_MUL: o_item.kind = K_MUL;
                OP_SDIV, OP_UDIV, OP_SREM, OP_UREM: begin
                    if (i_rhs_value != '0) o_item.kind = K_DIV;
                end
                default: o_item.tag = TAG_TOP;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/lcf_queue.sv
// Small FIFO between front end and execution back end.
`default_nettype none
module lcf_queue #(
    parameter int unsigned DEPTH = lcf_pkg::QDEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  lcf_pkg::t_item    i_item,
    input  wire logic         i_pop,
    output lcf_pkg::t_item    o_item,
    output logic              o_empty,
    output logic              o_full
);
    import lcf_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: sv/lcf_back.sv
// Back end: split multiplier and radix-2 divider, drives the result register.
`default_nettype none
module lcf_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  lcf_pkg::t_item    i_item,
    input  wire logic         i_empty,
    output logic              o_pop,
    output logic              o_valid,
    output logic [1:0]        o_result_tag,
    output logic [63:0]       o_result_value
);
    import lcf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_state;

    t_state          r_state;
    logic [VW-1:0]   r_p0;
    logic [HW-1:0]   r_p1, r_p2;
    logic [VW-1:0]   r_quot, r_rem, r_div;
    logic [5:0]      r_cnt;
    logic            r_neg_q, r_neg_r, r_want_rem;

    logic            sgn, sa, sb;
    logic [VW-1:0]   mag_a, mag_b;
    logic [VW:0]     shifted, trial;
    logic            qbit;
    logic [VW-1:0]   q_fin, r_fin;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        sgn   = (i_item.op == OP_SDIV) || (i_item.op == OP_SREM);
        sa    = sgn && i_item.a[VW-1];
        sb    = sgn && i_item.b[VW-1];
        mag_a = sa ? (~i_item.a + 1'b1) : i_item.a;
        mag_b = sb ? (~i_item.b + 1'b1) : i_item.b;
        shifted = {r_rem, r_quot[VW-1]};
        trial   = shifted - {1'b0, r_div};
        qbit    = !trial[VW];
        q_fin   = {r_quot[VW-2:0], qbit};
        r_fin   = qbit ? trial[VW-1:0] : shifted[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        case (i_item.kind)
                            K_MUL: begin
                                r_p0 <= {{HW{1'b0}}, i_item.a[HW-1:0]}
                                      * {{HW{1'b0}}, i_item.b[HW-1:0]};
                                r_p1 <= i_item.a[HW-1:0] * i_item.b[VW-1:HW];
                                r_p2 <= i_item.a[VW-1:HW] * i_item.b[HW-1:0];
                                r_state <= S_MUL;
                            end
                            K_DIV: begin
                                r_quot     <= mag_a;
                                r_div      <= mag_b;
                                r_rem      <= '0;
                                r_cnt      <= '0;
                                r_neg_q    <= sa ^ sb;
                                r_neg_r    <= sa;
                                r_want_rem <= (i_item.op == OP_SREM) ||
                                              (i_item.op == OP_UREM);
                                r_state    <= S_DIV;
                            end
                            default: begin
                                o_valid        <= 1'b1;
                                o_result_tag   <= i_item.tag;
                                o_result_value <= i_item.value;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    o_valid        <= 1'b1;
                    o_result_tag   <= TAG_CONST;
                    o_result_value <= r_p0 + {r_p1 + r_p2, {HW{1'b0}}};
                    r_state        <= S_IDLE;
                end
                S_DIV: begin
                    r_quot <= q_fin;
                    r_rem  <= r_fin;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 6'd63) begin
                        o_valid      <= 1'b1;
                        o_result_tag <= TAG_CONST;
                        if (r_want_rem)
                            o_result_value <= r_neg_r ? (~r_fin + 1'b1) : r_fin;
                        else
                            o_result_value <= r_neg_q ? (~q_fin + 1'b1) : q_fin;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/lattice_constant_fold_alu_top.sv
// Top level: constant-folding evaluator over the bottom/constant/top lattice.
// Usage:
//   Drive i_operation, tags and values with start high; the transaction is
//   taken on the rising edge where start is high and busy is low.
//   busy is high only while the internal queue (QUEUE_DEPTH entries) is full.
//   Every transaction yields one result, shown for one cycle with o_valid.
//   Results leave in the order transactions were taken.
// Path from acceptance to o_valid, through the queue and the back end:
//   bottom/top, add, sub, zero divisor, unknown op: folded in the front end
//   mul: three 32x32 partial products, then their sum
//   div/rem: one quotient bit per cycle in the radix-2 divider
// Throughput: one transaction per cycle for the folded cases while the back
//   end is idle; the back end runs one mul or div/rem item at a time and
//   takes no new one until it is done, while the front keeps filling the queue.
// Reset clears the queue and the result strobe; the receiver cannot stall,
//   so no result is ever held back.
`default_nettype none
module lattice_constant_fold_alu_top #(
    parameter int unsigned QUEUE_DEPTH = lcf_pkg::QDEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [2:0]   i_operation,
    input  wire logic [1:0]   i_lhs_tag,
    input  wire logic [63:0]  i_lhs_value,
    input  wire logic [1:0]   i_rhs_tag,
    input  wire logic [63:0]  i_rhs_value,
    output logic              o_valid,
    output logic [1:0]        o_result_tag,
    output logic [63:0]       o_result_value
);
    import lcf_pkg::*;

    t_item  front_item, head_item;
    logic   q_empty, q_full, q_pop, push;

    assign busy = q_full;
    assign push = start && !q_full;

    lcf_front u_front (
        .i_operation (i_operation),
        .i_lhs_tag   (i_lhs_tag),
        .i_lhs_value (i_lhs_value),
        .i_rhs_tag   (i_rhs_tag),
        .i_rhs_value (i_rhs_value),
        .o_item      (front_item)
    );

    lcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lcf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head_item),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .o_result_tag   (o_result_tag),
        .o_result_value (o_result_value)
    );

    a_tag_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_tag != 2'd3))
        else $error("illegal result tag");

    a_nonconst_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_tag != TAG_CONST) |-> (o_result_value == '0))
        else $error("non-constant result carries a value");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("activity right after reset");
endmodule
`default_nettype wire

// File: sim/tb_lattice_constant_fold_alu_top.sv
// Testbench for the lattice constant-folding evaluator: directed corners and random folds.
module tb_lattice_constant_fold_alu_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lcf_pkg::*;

    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  tag;
        logic [63:0] value;
    } t_folded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_operation = '0;
    logic [1:0]  i_lhs_tag = '0;
    logic [63:0] i_lhs_value = '0;
    logic [1:0]  i_rhs_tag = '0;
    logic [63:0] i_rhs_value = '0;
    logic        o_valid;
    logic [1:0]  o_result_tag;
    logic [63:0] o_result_value;

    t_folded pending_folds[$];
    int      error_count = 0;
    int      fold_count = 0;
    int      sent_count = 0;
    int      cycle_count = 0;
    bit      allow_gaps = 1'b1;

    lattice_constant_fold_alu_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_lhs_tag     (i_lhs_tag),
        .i_lhs_value   (i_lhs_value),
        .i_rhs_tag     (i_rhs_tag),
        .i_rhs_value   (i_rhs_value),
        .o_valid       (o_valid),
        .o_result_tag  (o_result_tag),
        .o_result_value(o_result_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_folded fold_lattice(logic [2:0] op, logic [1:0] lt, logic [63:0] lv,
                                             logic [1:0] rt, logic [63:0] rv);
        t_folded r;
        logic    ok;
        logic    min_neg;
        r.tag = TAG_TOP;
        r.value = '0;
        ok = 1'b1;
        min_neg = (lv == MIN_VAL) && (rv == NEG_ONE);
        if (lt == TAG_BOTTOM || rt == TAG_BOTTOM) begin
            r.tag = TAG_BOTTOM;
            return r;
        end
        if (lt != TAG_CONST || rt != TAG_CONST)
            return r;
        case (t_op'(op))
            OP_ADD: r.value = lv + rv;
            OP_SUB: r.value = lv - rv;
            OP_MUL: r.value = lv * rv;
            OP_SDIV: begin
                if (rv == 0) ok = 1'b0;
                else if (min_neg) r.value = MIN_VAL;
                else r.value = $signed(lv) / $signed(rv);
            end
            OP_UDIV: begin
                if (rv == 0) ok = 1'b0;
                else r.value = lv / rv;
            end
            OP_SREM: begin
                if (rv == 0) ok = 1'b0;
                else if (min_neg) r.value = '0;
                else r.value = $signed(lv) % $signed(rv);
            end
            OP_UREM: begin
                if (rv == 0) ok = 1'b0;
                else r.value = lv % rv;
            end
            default: ok = 1'b0;
        endcase
        if (ok) r.tag = TAG_CONST;
        else r.value = '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_folded exp_r;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_folds.size() == 0) begin
                $display("%0t: unexpected result tag=%0d value=%h", $time,
                         o_result_tag, o_result_value);
                error_count++;
            end else begin
                exp_r = pending_folds.pop_front();
                fold_count++;
                if (o_result_tag !== exp_r.tag) begin
                    $display("%0t: tag mismatch expected %0d actual %0d", $time,
                             exp_r.tag, o_result_tag);
                    error_count++;
                end
                if (o_result_value !== exp_r.value) begin
                    $display("%0t: value mismatch expected %h actual %h", $time,
                             exp_r.value, o_result_value);
                    error_count++;
                end
            end
        end
    end

    task automatic send_fold(logic [2:0] op, logic [1:0] lt, logic [63:0] lv,
                             logic [1:0] rt, logic [63:0] rv);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_lhs_tag <= lt;
        i_lhs_value <= lv;
        i_rhs_tag <= rt;
        i_rhs_value <= rv;
        do @(posedge i_clk); while (busy);
        pending_folds.push_back(fold_lattice(op, lt, lv, rt, rv));
        sent_count++;
    endtask

    task automatic drain_folds();
        start <= 1'b0;
        while (pending_folds.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return NEG_ONE;
            3: return 64'd0;
            4: return 64'd1;
            5: return 64'($urandom_range(0, 20));
            6: return -64'($urandom_range(1, 20));
            7: return {32'h0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic test_tags();
        for (int lt = 0; lt < 4; lt++)
            for (int rt = 0; rt < 4; rt++)
                send_fold(3'(OP_ADD), 2'(lt), 64'd5, 2'(rt), 64'd7);
    endtask

    task automatic test_corners();
        send_fold(3'(OP_SDIV), TAG_CONST, MIN_VAL, TAG_CONST, NEG_ONE);
        send_fold(3'(OP_SREM), TAG_CONST, MIN_VAL, TAG_CONST, NEG_ONE);
        send_fold(3'(OP_ADD), TAG_CONST, MAX_VAL, TAG_CONST, 64'd1);
        send_fold(3'(OP_SUB), TAG_CONST, MIN_VAL, TAG_CONST, 64'd1);
        send_fold(3'(OP_MUL), TAG_CONST, MAX_VAL, TAG_CONST, MAX_VAL);
        send_fold(3'(OP_SDIV), TAG_CONST, 64'd9, TAG_CONST, 64'd0);
        send_fold(3'(OP_UDIV), TAG_CONST, NEG_ONE, TAG_CONST, 64'd0);
        send_fold(3'(OP_SREM), TAG_CONST, -64'd7, TAG_CONST, 64'd2);
        send_fold(3'(OP_UREM), TAG_CONST, NEG_ONE, TAG_CONST, 64'd10);
        send_fold(3'(OP_OTHER), TAG_CONST, 64'd3, TAG_CONST, 64'd4);
        drain_folds();
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        logic [1:0] lt;
        logic [1:0] rt;
        for (int n = 0; n < count; n++) begin
            op = 3'($urandom_range(0, 7));
            lt = ($urandom_range(0, 9) < 8) ? TAG_CONST : 2'($urandom_range(0, 3));
            rt = ($urandom_range(0, 9) < 8) ? TAG_CONST : 2'($urandom_range(0, 3));
            send_fold(op, lt, pick_value(), rt, pick_value());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tags();
        test_corners();
        test_random(500);
        drain_folds();
        test_random(200);
        allow_gaps = 1'b0;
        test_random(150);
        drain_folds();
        repeat (80) @(posedge i_clk);
        $display("Covered %0d transactions: all tag pairs, every operation,", sent_count);
        $display("zero divisors, wrap and min/-1 cases; %0d results checked.", fold_count);
        if (error_count == 0 && pending_folds.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
